FILE: rtl/stn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Score table package
// Shared types and constants of the sorted top-N score table.
// ----------------------------------------------------------------------------
package stn_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [30:0] score;
    logic [7:0]  level;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] cand_id;
    logic [30:0] cand_score;
    logic [7:0]  cand_level;
    logic [3:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        was_duplicate;
    logic [15:0] out_id;
    logic [30:0] out_score;
    logic [7:0]  out_level;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/stn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Score table channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface stn_in_if;
  logic             valid;
  logic             ready;
  stn_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stn_out_if;
  logic              valid;
  logic              ready;
  stn_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/stn_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Score table storage
// Entry memory with one write and one registered read port; per-entry valid
// bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module stn_table #(
  parameter int DEPTH = stn_pkg::DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [AW-1:0]   raddr,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire stn_pkg::entry_t wdata,
  output stn_pkg::entry_t      rdata
);
  import stn_pkg::*;

  entry_t           mem [DEPTH];
  entry_t           mem_q;
  logic [DEPTH-1:0] vld;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      vld_q <= vld[raddr];
    end
  end

  assign rdata = vld_q ? mem_q : '0;

endmodule
`default_nettype wire

FILE: rtl/sorted_top_n_score_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted top-N score table
// Keeps DEPTH entries in descending score order in one memory; inserts scan
// the table once for duplicates and placement, then ripple entries down.
// ----------------------------------------------------------------------------
// Read: the registered table read is captured in RDW and moved to the output
//   register in FIN. Insert: a rejected insert ends after the scan, a placed
//   one after the shift; a new request is taken only back in idle. The single
//   memory read port handles one entry per cycle in scan and shift.
// A new request is taken while an earlier result still waits at the output.
// Reset (synchronous) empties the table at once: all entries read as zero.
// ----------------------------------------------------------------------------
module sorted_top_n_score_table_core #(
  parameter int DEPTH = stn_pkg::DEPTH_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  stn_in_if.sink    req,
  stn_out_if.source rsp
);
  import stn_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_RDW   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t    st;
  in_item_t  cur;
  logic [AW-1:0] cnt;
  logic [AW-1:0] pos;
  logic      found;
  logic      dup;
  logic      idx_ok;
  entry_t    hold;
  out_item_t res;
  out_item_t o_q;
  logic      o_vld;

  entry_t        cand;
  entry_t        e;
  logic [AW-1:0] raddr;
  logic [AW-1:0] pos_sel;
  logic          we;
  logic          last;
  logic          match;
  logic          lower;

  stn_table #(.DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .rst   (rst),
    .raddr (raddr),
    .we    (we),
    .waddr (cnt),
    .wdata (hold),
    .rdata (e)
  );

  assign req.ready = (st == ST_IDLE);
  assign rsp.valid = o_vld;
  assign rsp.data  = o_q;

  always_comb begin
    cand.id    = cur.cand_id;
    cand.score = cur.cand_score;
    cand.level = cur.cand_level;
    last    = (cnt == LAST);
    match   = (e == cand);
    lower   = (e.score < cand.score);
    pos_sel = found ? pos : LAST;
    we      = (st == ST_SHIFT);
    raddr   = cnt + AW'(1);
    case (st)
      ST_IDLE: begin
        raddr = (req.data.kind == KIND_READ) ? AW'(req.data.read_index) : '0;
      end
      ST_SCAN: begin
        if (last) begin
          raddr = pos_sel;
        end
      end
      default: begin
        raddr = cnt + AW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      o_vld <= 1'b0;
    end else begin
      if (st == ST_FIN && (!o_vld || rsp.ready)) begin
        o_vld <= 1'b1;
      end else if (rsp.ready) begin
        o_vld <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (req.valid) begin
            cur    <= req.data;
            cnt    <= '0;
            dup    <= 1'b0;
            found  <= 1'b0;
            idx_ok <= (32'(req.data.read_index) < 32'(DEPTH));
            st     <= (req.data.kind == KIND_READ) ? ST_RDW : ST_SCAN;
          end
        end
        ST_RDW: begin
          res <= {2'b00, idx_ok ? e : entry_t'(0)};
          st  <= ST_FIN;
        end
        ST_SCAN: begin
          dup <= dup | match;
          if (!found && lower && !last) begin
            found <= 1'b1;
            pos   <= cnt;
          end
          cnt <= last ? pos_sel : cnt + AW'(1);
          if (last) begin
            if (dup || match) begin
              res <= {1'b0, 1'b1, entry_t'(0)};
              st  <= ST_FIN;
            end else if (!lower) begin
              res <= '0;
              st  <= ST_FIN;
            end else begin
              hold <= cand;
              st   <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          hold <= e;
          cnt  <= cnt + AW'(1);
          if (last) begin
            res <= {1'b1, 1'b0, entry_t'(0)};
            st  <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!o_vld || rsp.ready) begin
            o_q <= res;
            st  <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  a_insert_scans: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.data.kind == KIND_INSERT) |=> st == ST_SCAN)
    else $error("insert transfer did not start a scan");

  a_shift_lower: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SHIFT) |-> hold.score <= cur.cand_score)
    else $error("displaced entry outranks the candidate");

  a_shift_accepts: assert property (@(posedge clk) disable iff (rst)
    (st == ST_FIN && $past(st) == ST_SHIFT) |-> res.accepted && !res.was_duplicate)
    else $error("placed insert not reported as accepted");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    o_vld |-> !(o_q.accepted && o_q.was_duplicate))
    else $error("result both accepted and duplicate");

  a_write_in_shift: assert property (@(posedge clk) disable iff (rst)
    we |-> (cnt != raddr))
    else $error("write and read collide on one entry");

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Sorted top-N score table testbench
// Sends insert and read requests through the request channel and checks each
// result against a shadow table kept here in descending score order. Both
// channels idle at random, with stretches where they run back to back.
// ----------------------------------------------------------------------------
module tb;
  import stn_pkg::*;

  localparam int DEPTH      = DEPTH_DEFAULT;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 2 * DEPTH + 8;

  logic clk;
  logic rst;

  stn_in_if  req_ch ();
  stn_out_if rsp_ch ();

  sorted_top_n_score_table_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  entry_t    shadow_slots [DEPTH];
  out_item_t due_results [$];
  int        mismatches;
  bit        steady;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic out_item_t score_table_predict(input in_item_t it);
    out_item_t r;
    entry_t    cand;
    int        pos;
    r = '0;
    if (it.kind == KIND_READ) begin
      if (int'(it.read_index) < DEPTH) begin
        r.out_id    = shadow_slots[it.read_index].id;
        r.out_score = shadow_slots[it.read_index].score;
        r.out_level = shadow_slots[it.read_index].level;
      end
      return r;
    end
    cand = '{id: it.cand_id, score: it.cand_score, level: it.cand_level};
    foreach (shadow_slots[i]) begin
      if (shadow_slots[i] == cand) begin
        r.was_duplicate = 1'b1;
        return r;
      end
    end
    if (!(cand.score > shadow_slots[DEPTH-1].score)) begin
      return r;
    end
    pos = DEPTH - 1;
    for (int k = 0; k < DEPTH - 1; k++) begin
      if (shadow_slots[k].score < cand.score) begin
        pos = k;
        break;
      end
    end
    for (int k = DEPTH - 1; k > pos; k--) begin
      shadow_slots[k] = shadow_slots[k-1];
    end
    shadow_slots[pos] = cand;
    r.accepted = 1'b1;
    return r;
  endfunction

  function automatic in_item_t insert_item(input logic [15:0] id, input logic [30:0] score,
                                           input logic [7:0] level);
    in_item_t it;
    it.kind       = KIND_INSERT;
    it.cand_id    = id;
    it.cand_score = score;
    it.cand_level = level;
    it.read_index = 4'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input logic [3:0] idx);
    in_item_t it;
    it.kind       = KIND_READ;
    it.cand_id    = 16'($urandom);
    it.cand_score = 31'($urandom);
    it.cand_level = 8'($urandom);
    it.read_index = idx;
    return it;
  endfunction

  // valid stays high after a transfer; the next call lowers it or reloads data
  task automatic send_item(input in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(18, 0);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    do @(posedge clk); while (!req_ch.ready);
    due_results.push_back(score_table_predict(it));
  endtask

  task automatic wait_for_results;
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_table;
    send_item(read_item(4'd0));
    send_item(read_item(4'(DEPTH - 1)));
    send_item(insert_item(16'd0, 31'd0, 8'd0));
  endtask

  task automatic test_extremes;
    send_item(insert_item(16'hFFFF, 31'h7FFF_FFFF, 8'hFF));
    send_item(insert_item(16'hFFFF, 31'h7FFF_FFFF, 8'hFF));
    send_item(insert_item(16'h0000, 31'd1, 8'h00));
    send_item(insert_item(16'h0001, 31'd1, 8'h80));
    send_item(insert_item(16'h0005, 31'd0, 8'h11));
    send_item(insert_item(16'h0000, 31'd0, 8'h00));
    send_item(insert_item(16'h0002, 31'h7FFF_FFFF, 8'h01));
    for (int i = 0; i < 5; i++) begin
      send_item(read_item(4'(i)));
    end
    send_item(read_item(4'hF));
  endtask

  task automatic test_drain_pause;
    steady = 1'b1;
    for (int i = 0; i < 6; i++) begin
      send_item(insert_item(16'($urandom), 31'($urandom_range(40, 1)), 8'($urandom)));
    end
    wait_for_results();
    send_item(read_item(4'd3));
    steady = 1'b0;
  endtask

  task automatic test_random(input int count);
    in_item_t it;
    entry_t   pick;
    int       sel;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        steady = ($urandom_range(3, 0) == 0);
      end
      sel  = $urandom_range(99, 0);
      pick = shadow_slots[$urandom_range(DEPTH - 1, 0)];
      it   = insert_item(16'($urandom), 31'($urandom), 8'($urandom));
      if (sel < 25) begin
        it = read_item(4'($urandom));
      end else if (sel < 40) begin
        it.cand_score = pick.score;
      end else if (sel < 52) begin
        it = insert_item(pick.id, pick.score, pick.level);
      end else if (sel < 62) begin
        it.cand_score = 31'($urandom_range(64, 0));
      end else if (sel < 70) begin
        it.cand_score = shadow_slots[DEPTH-1].score + 31'($urandom_range(1, 0));
      end else if (sel < 75) begin
        it.cand_level = pick.level;
        it.cand_score = pick.score;
      end
      send_item(it);
    end
  endtask

  initial begin : result_checker
    out_item_t got;
    out_item_t want;
    int        stall;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(18, 0);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      got = rsp_ch.data;
      if (due_results.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = due_results.pop_front();
        if (got.accepted !== want.accepted)
          flag_mismatch($sformatf("accepted %0b, want %0b", got.accepted, want.accepted));
        if (got.was_duplicate !== want.was_duplicate)
          flag_mismatch($sformatf("was_duplicate %0b, want %0b",
                                  got.was_duplicate, want.was_duplicate));
        if (got.out_id !== want.out_id)
          flag_mismatch($sformatf("out_id %h, want %h", got.out_id, want.out_id));
        if (got.out_score !== want.out_score)
          flag_mismatch($sformatf("out_score %h, want %h", got.out_score, want.out_score));
        if (got.out_level !== want.out_level)
          flag_mismatch($sformatf("out_level %h, want %h", got.out_level, want.out_level));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    steady       = 1'b0;
    mismatches   = 0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_extremes();
    test_drain_pause();
    test_random(450);

    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (due_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", due_results.size()));
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
